### design/note_priority_voice_stack_unit_macros.svh
// Assertion macros used by the voice stack top level.
`ifndef NOTE_PRIORITY_VOICE_STACK_UNIT_MACROS_SVH
`define NOTE_PRIORITY_VOICE_STACK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define NVS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NVS_ASSERT(lbl, prop, msg) \
  `NVS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define NVS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define NVS_ASSERT(lbl, prop, msg)
`endif

`endif

### design/nvs_pkg.sv
// Types and constants of the note priority voice stack.
package nvs_pkg;

  localparam int unsigned SlotsDef   = 4;
  localparam int unsigned OutSlots   = 4;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam logic [3:0]  EmptyNote  = 4'd12;
  localparam logic [3:0]  EmptyOct   = 4'd4;

  typedef enum logic [AddrW-1:0] {
    RegReceiverMode = 3'd0
  } reg_addr_e;

  typedef struct packed {
    logic [3:0] note;
    logic [3:0] octave;
  } slot_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] note;
    logic [3:0] octave;
  } in_t;

  typedef struct packed {
    logic [3:0] slot0_note;
    logic [3:0] slot0_octave;
    logic [3:0] slot1_note;
    logic [3:0] slot1_octave;
    logic [3:0] slot2_note;
    logic [3:0] slot2_octave;
    logic [3:0] slot3_note;
    logic [3:0] slot3_octave;
    logic       release_matched;
  } out_t;

  typedef struct packed {
    logic  press;
    logic  release_key;
    slot_t key;
  } cell_ctrl_t;

  localparam slot_t EmptySlot = '{note: EmptyNote, octave: EmptyOct};

endpackage

### design/nvs_cell.sv
// One voice slot of the stack: holds a note and octave, shifts or compacts with its neighbors.
module nvs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nvs_pkg::cell_ctrl_t ctrl_i,
  input  nvs_pkg::slot_t     prev_i,
  input  nvs_pkg::slot_t     next_i,
  input  logic               hit_i,
  output logic               hit_o,
  output nvs_pkg::slot_t     slot_q_o,
  output nvs_pkg::slot_t     slot_d_o
);
  import nvs_pkg::*;

  slot_t slot_q, slot_d;
  logic  match;

  assign match = ctrl_i.release_key && (slot_q.note == ctrl_i.key.note)
                 && (slot_q.octave == ctrl_i.key.octave);
  assign hit_o = hit_i | match;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.press) begin
      slot_d = prev_i;
    end else if (ctrl_i.release_key && hit_o) begin
      slot_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= EmptySlot;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_q_o = slot_q;
  assign slot_d_o = slot_d;

endmodule

### design/note_priority_voice_stack_unit.sv
// Top level of the note priority voice stack: cell chain, result register and APB register.
// Each accepted key event (receiver mode on, note below 12) updates a chain of Slots voice
// cells in the cycle of its transfer, and its result, the new contents of slots 0 to 3 with
// the release match flag, is held in a single output register from the next cycle on. One
// event is taken per cycle while results are taken as they appear; the output register is
// the only stage, so a new event enters in the same cycle that the waiting result is
// transferred. Release matching ripples combinationally through cells 0 to Slots-1.
`include "note_priority_voice_stack_unit_macros.svh"

module note_priority_voice_stack_unit #(
  parameter int unsigned Slots = nvs_pkg::SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  nvs_pkg::in_t               in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nvs_pkg::out_t              out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nvs_pkg::AddrW-1:0]  paddr,
  input  logic [nvs_pkg::DataW-1:0]  pwdata,
  output logic [nvs_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import nvs_pkg::*;

  logic       mode_q, mode_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       in_fire, active;
  cell_ctrl_t ctrl;
  slot_t      slot_q [Slots];
  slot_t      slot_d [Slots];
  logic [Slots:0] hit;
  slot_t      view [OutSlots];

  assign pready = 1'b1;
  assign prdata = (paddr == RegReceiverMode) ? {{(DataW-1){1'b0}}, mode_q} : '0;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && (paddr == RegReceiverMode)) begin
      mode_d = pwdata[0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign active     = in_fire && mode_q && (in_i.note < EmptyNote);

  assign ctrl.press       = active && !in_i.req_type;
  assign ctrl.release_key = active && in_i.req_type;
  assign ctrl.key.note    = in_i.note;
  assign ctrl.key.octave  = in_i.octave;
  assign hit[0]           = 1'b0;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    nvs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .prev_i   ((g == 0) ? ctrl.key : slot_q[(g == 0) ? 0 : g - 1]),
      .next_i   ((g == Slots - 1) ? EmptySlot : slot_q[(g == Slots - 1) ? g : g + 1]),
      .hit_i    (hit[g]),
      .hit_o    (hit[g+1]),
      .slot_q_o (slot_q[g]),
      .slot_d_o (slot_d[g])
    );
  end

  for (genvar k = 0; k < OutSlots; k++) begin : g_view
    if (k < Slots) begin : g_real
      assign view[k] = slot_d[k];
    end else begin : g_empty
      assign view[k] = EmptySlot;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d           = 1'b1;
      out_d.slot0_note      = view[0].note;
      out_d.slot0_octave    = view[0].octave;
      out_d.slot1_note      = view[1].note;
      out_d.slot1_octave    = view[1].octave;
      out_d.slot2_note      = view[2].note;
      out_d.slot2_octave    = view[2].octave;
      out_d.slot3_note      = view[3].note;
      out_d.slot3_octave    = view[3].octave;
      out_d.release_matched = ctrl.release_key && hit[Slots];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `NVS_ASSERT(a_result_follows_transfer, $rose(out_valid_o) |-> $past(in_fire), "Result without input transfer.")
  `NVS_ASSERT(a_press_never_matches, (in_fire && !in_i.req_type) |=> !out_o.release_matched, "Press reported a release match.")
  `NVS_ASSERT(a_idle_mode_holds, (in_fire && !mode_q) |=> (out_o.slot0_note == $past(slot_q[0].note) && !out_o.release_matched), "Events changed slots while receiver mode was off.")

endmodule
